### rtl/rau_pkg.sv
// ============================================================================
// rau_pkg
// shared types and constants for the rational arithmetic unit
// ============================================================================
package rau_pkg;

    localparam int OPERAND_BITS_DEF = 32;
    localparam int WIDE_BITS        = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_ZERODEN = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_CHECK,
        S_GCD_START,
        S_GCD_DIV,
        S_GCD_STEP,
        S_RED_NUM,
        S_RED_DEN,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic gcd_start;
        logic div_start;
        logic gcd_step;
        logic red_num_start;
        logic red_num_done;
        logic red_den_start;
        logic red_den_done;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic    early;
        status_t early_status;
        logic    gcd_y_zero;
        logic    div_done;
    } dp_stat_t;

endpackage

### rtl/rau_if.sv
// ============================================================================
// rau_in_if / rau_out_if
// valid/ready channels for operands and results
// ============================================================================
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0]  status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink (input valid, res_num, res_den, status, output ready);
endinterface

### rtl/rau_divider.sv
// ============================================================================
// rau_divider
// 64-bit unsigned restoring divider, one quotient bit per cycle
// ============================================================================
module rau_divider
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[63]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = busy_reg && (cnt_reg == 7'd1);
    assign quotient  = q_next;
    assign remainder = r_next;

endmodule

### rtl/rau_datapath.sv
// ============================================================================
// rau_datapath
// operand registers, cross products, sum, gcd and reduction
// ============================================================================
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  operation,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic [63:0] res_num,
    output logic [62:0] res_den,
    output logic [1:0]  status
);

    localparam int OB = OPERAND_BITS;

    op_t         op_reg;
    logic [OB-1:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic        an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [63:0] p1_reg, p2_reg, p3_reg, n_reg, d_reg, x_reg, y_reg;
    logic        p1_s_reg, p2_s_reg, n_s_reg, d_s_reg;
    logic [63:0] res_num_reg;
    logic [62:0] res_den_reg;
    status_t     status_reg, early_status;
    logic        early;

    logic [63:0] div_a, div_b, quo, rem;
    logic        div_done;

    function automatic logic [OB-1:0] mag_of(input logic [31:0] raw);
        logic [OB-1:0] v;
        v = raw[OB-1:0];
        return v[OB-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        early        = 1'b0;
        early_status = ST_OK;
        if (op_reg == OP_DIV && bn_m_reg == '0)
        begin
            early        = 1'b1;
            early_status = ST_DIVZERO;
        end
        else if (ad_m_reg == '0 || bd_m_reg == '0)
        begin
            early        = 1'b1;
            early_status = ST_ZERODEN;
        end
    end

    assign div_a = cmd.red_num_start ? n_reg : (cmd.red_den_start ? d_reg : x_reg);
    assign div_b = (cmd.red_num_start || cmd.red_den_start) ? x_reg : y_reg;

    rau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start || cmd.red_num_start || cmd.red_den_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    logic [OB-1:0] pa, pb;
    logic        sa, sb;
    logic        bn_s_eff;
    always_comb
    begin
        bn_s_eff = (op_reg == OP_SUB) ? ~bn_s_reg : bn_s_reg;
        if (cmd.mul1)
        begin
            pa = an_m_reg;
            sa = an_s_reg;
            pb = (op_reg == OP_MUL) ? bn_m_reg : bd_m_reg;
            sb = (op_reg == OP_MUL) ? bn_s_eff : bd_s_reg;
        end
        else
        begin
            pa = ad_m_reg;
            sa = ad_s_reg;
            pb = (op_reg == OP_DIV) ? bn_m_reg : bd_m_reg;
            sb = (op_reg == OP_DIV) ? bn_s_eff : bd_s_reg;
        end
    end

    logic [2*OB-1:0] prod_w;
    logic [63:0]     prod;
    assign prod_w = pa * pb;
    assign prod   = 64'(prod_w);
    // ad*bn for add/sub numerator, registered with the second product
    logic [2*OB-1:0] prod3_w;
    assign prod3_w = ad_m_reg * bn_m_reg;

    logic [63:0] sum_m;
    logic        sum_s;
    logic        t_s;
    always_comb
    begin
        t_s = (ad_s_reg != bn_s_eff) && p3_reg != '0;
        if (p1_s_reg == t_s)
        begin
            sum_m = p1_reg + p3_reg;
            sum_s = p1_s_reg;
        end
        else if (p1_reg >= p3_reg)
        begin
            sum_m = p1_reg - p3_reg;
            sum_s = p1_s_reg;
        end
        else
        begin
            sum_m = p3_reg - p1_reg;
            sum_s = t_s;
        end
        if (sum_m == '0)
        begin
            sum_s = 1'b0;
        end
    end

    logic [63:0] out_n_m, out_d_m;
    logic        out_n_s, out_d_s;
    logic        neg;
    always_comb
    begin
        if (early_status == ST_DIVZERO)
        begin
            out_n_m = 64'(an_m_reg);
            out_n_s = an_s_reg;
            out_d_m = 64'(ad_m_reg);
            out_d_s = ad_s_reg;
        end
        else
        begin
            out_n_m = n_reg;
            out_n_s = n_s_reg;
            out_d_m = d_reg;
            out_d_s = d_s_reg;
        end
        neg = (out_n_s != out_d_s) && out_n_m != '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(operation);
            an_m_reg <= mag_of(a_num);
            ad_m_reg <= mag_of(a_den);
            bn_m_reg <= mag_of(b_num);
            bd_m_reg <= mag_of(b_den);
            an_s_reg <= a_num[OB-1];
            ad_s_reg <= a_den[OB-1];
            bn_s_reg <= b_num[OB-1];
            bd_s_reg <= b_den[OB-1];
        end
        if (cmd.mul1)
        begin
            p1_reg   <= prod;
            p1_s_reg <= (sa != sb) && prod != '0;
        end
        if (cmd.mul2)
        begin
            p2_reg   <= prod;
            p2_s_reg <= (sa != sb) && prod != '0;
            p3_reg   <= 64'(prod3_w);
        end
        if (cmd.sum)
        begin
            if (op_reg == OP_ADD || op_reg == OP_SUB)
            begin
                n_reg   <= sum_m;
                n_s_reg <= sum_s;
            end
            else
            begin
                n_reg   <= p1_reg;
                n_s_reg <= p1_s_reg;
            end
            d_reg   <= p2_reg;
            d_s_reg <= p2_s_reg;
        end
        if (cmd.gcd_start)
        begin
            x_reg <= n_reg;
            y_reg <= d_reg;
        end
        if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= rem;
        end
        if (cmd.red_num_done)
        begin
            n_reg <= quo;
        end
        if (cmd.red_den_done)
        begin
            d_reg <= quo;
        end
        if (cmd.out_load)
        begin
            res_num_reg <= neg ? (64'd0 - out_n_m) : out_n_m;
            res_den_reg <= out_d_m[62:0];
            status_reg  <= early ? early_status : ST_OK;
        end
    end

    assign stat.early        = early;
    assign stat.early_status = early_status;
    assign stat.gcd_y_zero   = (y_reg == '0);
    assign stat.div_done     = div_done;

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

endmodule

### rtl/rau_ctrl.sv
// ============================================================================
// rau_ctrl
// sequencer for the rational arithmetic unit
// ============================================================================
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat,
    output ctrl_state_t state
);

    ctrl_state_t state_reg, state_next;
    logic        ov_reg, ov_next;
    logic        red_den_reg, red_den_next;

    always_comb
    begin
        state_next   = state_reg;
        red_den_next = red_den_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_SUM;
            S_SUM:  state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = stat.early ? S_OUT : S_GCD_START;
            end
            S_GCD_START: state_next = S_GCD_DIV;
            S_GCD_DIV:
            begin
                if (stat.gcd_y_zero)
                begin
                    state_next = S_RED_NUM;
                end
                else
                begin
                    state_next = S_GCD_STEP;
                end
            end
            S_GCD_STEP:
            begin
                if (stat.div_done)
                begin
                    state_next = S_GCD_DIV;
                end
            end
            S_RED_NUM:
            begin
                if (stat.div_done)
                begin
                    if (red_den_reg)
                    begin
                        state_next   = S_OUT;
                        red_den_next = 1'b0;
                    end
                    else
                    begin
                        state_next   = S_RED_DEN;
                        red_den_next = 1'b1;
                    end
                end
            end
            S_RED_DEN: state_next = S_RED_NUM;
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        ov_next       = ov_reg && !out_ready;
        in_ready      = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:    cmd.load = in_valid;
            S_MUL1:    cmd.mul1 = 1'b1;
            S_MUL2:    cmd.mul2 = 1'b1;
            S_SUM:     cmd.sum  = 1'b1;
            S_GCD_START: cmd.gcd_start = 1'b1;
            S_GCD_DIV:
            begin
                cmd.div_start     = !stat.gcd_y_zero;
                cmd.red_num_start = stat.gcd_y_zero && !red_den_reg;
            end
            S_GCD_STEP: cmd.gcd_step = stat.div_done;
            S_RED_NUM:
            begin
                cmd.red_num_done = stat.div_done && !red_den_reg;
                cmd.red_den_done = stat.div_done && red_den_reg;
            end
            S_RED_DEN: cmd.red_den_start = 1'b1;
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
            red_den_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ov_reg      <= ov_next;
            red_den_reg <= red_den_next;
        end
    end

    assign out_valid = ov_reg;
    assign state     = state_reg;

endmodule

### rtl/rational_arith_unit.sv
// a divide-by-zero or zero-denominator item goes straight to the output; else
// the item runs the gcd and reduction: each gcd step and each of the two
// reductions runs the restoring divider
// throughput: one item at a time; the next is taken once the result is registered
// reset: rst_n asynchronous active low clears the sequencer and output valid
// ============================================================================
// rational_arith_unit
// signed fraction add/sub/mul/div with gcd reduction
// ============================================================================
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    ctrl_state_t state;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat),
        .state     (state)
    );

    rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operation (in_ch.operation),
        .a_num     (in_ch.a_num),
        .a_den     (in_ch.a_den),
        .b_num     (in_ch.b_num),
        .b_den     (in_ch.b_den),
        .res_num   (out_ch.res_num),
        .res_den   (out_ch.res_den),
        .status    (out_ch.status)
    );

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.status != 2'd3) else $error("bad status");
`endif

endmodule
